@@ rtl/rpn_stack_evaluator_macros.svh @@
// ---------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Shorthand for clocked concurrent checks with async reset disable.
// ---------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// property must hold on every clock edge outside reset
`define RSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rse: assertion failed");

// condition must never be true outside reset
`define RSE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `RSE_ASSERT(lbl, clk, rst_n, !(cond))

`endif

@@ rtl/rse_pkg.sv @@
// ---------------------------------------------------------------------------
// RPN stack evaluator package
// Shared constants, codes and request/result types.
// ---------------------------------------------------------------------------
package rse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_MOD     = 3'd5,
    OP_UNKNOWN = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  // per-cell shift command
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,     // take value from above (cell 0: new value)
    STK_PULL1,    // take value one below
    STK_PULL2     // take value two below
  } stk_cmd_e;

  typedef enum logic [0:0] {
    TS_IDLE,
    TS_DIV
  } top_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIX
  } div_state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [30:0] operand;
    logic        last_token;
  } token_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         stack_depth;
    logic [2:0]         status;
    logic               expression_end;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    logic              is_mod;
  } div_req_t;

endpackage

@@ rtl/rse_cell.sv @@
// ---------------------------------------------------------------------------
// RPN stack cell
// One stack entry; shifts toward the bottom on push, toward the top on pop.
// ---------------------------------------------------------------------------
module rse_cell (
  input  logic                           clk_i,
  input  rse_pkg::stk_cmd_e              cmd_i,
  input  logic [rse_pkg::DATA_W-1:0]     up_i,
  input  logic [rse_pkg::DATA_W-1:0]     dn1_i,
  input  logic [rse_pkg::DATA_W-1:0]     dn2_i,
  output logic [rse_pkg::DATA_W-1:0]     value_o
);

  logic [rse_pkg::DATA_W-1:0] value_q;
  logic [rse_pkg::DATA_W-1:0] value_d;

  always_comb begin
    unique case (cmd_i)
      rse_pkg::STK_PUSH:  value_d = up_i;
      rse_pkg::STK_PULL1: value_d = dn1_i;
      rse_pkg::STK_PULL2: value_d = dn2_i;
      default:            value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ rtl/rse_divider.sv @@
// ---------------------------------------------------------------------------
// RPN signed divider
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// then a sign fix; returns quotient or remainder truncated toward zero.
// ---------------------------------------------------------------------------
module rse_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rse_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [rse_pkg::DATA_W-1:0]  result_o
);

  localparam int unsigned W = rse_pkg::DATA_W;

  rse_pkg::div_state_e state_q, state_d;

  logic [rse_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] dvs_q, dvs_d;
  logic         neg_q_q, neg_q_d;   // quotient sign
  logic         neg_r_q, neg_r_d;   // remainder sign
  logic         is_mod_q, is_mod_d;
  logic [W-1:0] result_q, result_d;
  logic         done_q, done_d;

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic [W-1:0] mag;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    neg_q_d  = neg_q_q;
    neg_r_d  = neg_r_q;
    is_mod_d = is_mod_q;
    result_d = result_q;
    done_d   = 1'b0;
    rem_sh   = {rem_q, quo_q[W-1]};
    diff     = rem_sh - {1'b0, dvs_q};
    mag      = is_mod_q ? rem_q : quo_q;

    unique case (state_q)
      rse_pkg::DV_IDLE: begin
        if (start_i) begin
          quo_d    = req_i.dividend[W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
          dvs_d    = req_i.divisor[W-1] ? (~req_i.divisor + 1'b1) : req_i.divisor;
          rem_d    = '0;
          cnt_d    = '0;
          neg_q_d  = req_i.dividend[W-1] ^ req_i.divisor[W-1];
          neg_r_d  = req_i.dividend[W-1];
          is_mod_d = req_i.is_mod;
          state_d  = rse_pkg::DV_RUN;
        end
      end
      rse_pkg::DV_RUN: begin
        if (!diff[W]) begin
          rem_d = diff[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rse_pkg::DIV_CNT_W'(rse_pkg::DIV_STEPS - 1)) begin
          state_d = rse_pkg::DV_FIX;
        end
      end
      rse_pkg::DV_FIX: begin
        if (is_mod_q ? neg_r_q : neg_q_q) begin
          result_d = ~mag + 1'b1;
        end else begin
          result_d = mag;
        end
        done_d  = 1'b1;
        state_d = rse_pkg::DV_IDLE;
      end
      default: state_d = rse_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rse_pkg::DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dvs_q    <= dvs_d;
    neg_q_q  <= neg_q_d;
    neg_r_q  <= neg_r_d;
    is_mod_q <= is_mod_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/rpn_stack_evaluator.sv @@
// ---------------------------------------------------------------------------
// RPN stack evaluator
// Reverse Polish evaluator over a 16-entry signed 32-bit operand stack.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// result_o for one cycle with result_valid_o, in the cycle after the request for
// push, add, subtract, multiply and all error cases, and the receiver cannot
// stall it. Those requests can be issued every cycle. Divide and modulo with
// a nonzero divisor hold busy high through the radix-2 divider's iterations,
// its sign-fix step and the writeback. The stack is a row of cells that shift
// in place; entries never written read back as undefined, and no clearing
// pass is needed.
// ---------------------------------------------------------------------------
module rpn_stack_evaluator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  rse_pkg::token_t    token_i,
  output logic               result_valid_o,
  output rse_pkg::result_t   result_o
);

  `include "rpn_stack_evaluator_macros.svh"

  localparam int unsigned W     = rse_pkg::DATA_W;
  localparam int unsigned DEPTH = rse_pkg::STACK_DEPTH;
  localparam int unsigned CW    = rse_pkg::CNT_W;

  rse_pkg::top_state_e state_q, state_d;

  logic [CW-1:0]     count_q, count_d;
  logic              last_q, last_d;
  logic              valid_q, valid_d;
  rse_pkg::result_t  res_q, res_d;

  logic [W-1:0]      cell_q [DEPTH];
  rse_pkg::stk_cmd_e cmd;
  logic [W-1:0]      new_val;
  logic [W-1:0]      top_val, nxt_val, third_val;
  logic [CW-1:0]     depth_nx;
  logic [W-1:0]      out_top;
  logic [2:0]        status;

  logic              accept;
  logic              div_start;
  rse_pkg::div_req_t div_req;
  logic              div_done;
  logic [W-1:0]      div_result;

  assign busy    = (state_q != rse_pkg::TS_IDLE);
  assign accept  = start && !busy;
  assign top_val = cell_q[0];
  assign nxt_val = cell_q[1];

  // ---------------- stack cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rse_pkg::stk_cmd_e cell_cmd;
    logic [W-1:0]      up, dn1, dn2;

    if (i == 0) begin : g_top
      assign up       = new_val;
      // cell 0 loads the op result where the rest pull up by one
      assign cell_cmd = (cmd == rse_pkg::STK_PULL1) ? rse_pkg::STK_PUSH : cmd;
    end else begin : g_mid
      assign up       = cell_q[i-1];
      assign cell_cmd = cmd;
    end
    if (i + 1 < DEPTH) begin : g_dn1
      assign dn1 = cell_q[i+1];
    end else begin : g_dn1_end
      assign dn1 = '0;
    end
    if (i + 2 < DEPTH) begin : g_dn2
      assign dn2 = cell_q[i+2];
    end else begin : g_dn2_end
      assign dn2 = '0;
    end

    rse_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .up_i    (up),
      .dn1_i   (dn1),
      .dn2_i   (dn2),
      .value_o (cell_q[i])
    );
  end

  if (DEPTH > 2) begin : g_third
    assign third_val = cell_q[2];
  end else begin : g_no_third
    assign third_val = '0;
  end

  // ---------------- divider
  assign div_req.dividend = nxt_val;
  assign div_req.divisor  = top_val;
  assign div_req.is_mod   = (token_i.opcode == rse_pkg::OP_MOD);

  rse_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .req_i    (div_req),
    .done_o   (div_done),
    .result_o (div_result)
  );

  // ---------------- control
  always_comb begin
    state_d   = state_q;
    cmd       = rse_pkg::STK_HOLD;
    new_val   = '0;
    depth_nx  = count_q;
    status    = rse_pkg::ST_OK;
    out_top   = top_val;
    div_start = 1'b0;
    last_d    = last_q;
    valid_d   = 1'b0;

    unique case (state_q)
      rse_pkg::TS_IDLE: begin
        if (accept) begin
          last_d  = token_i.last_token;
          valid_d = 1'b1;
          case (token_i.opcode) inside
            rse_pkg::OP_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                status = rse_pkg::ST_OVER;
              end else begin
                cmd      = rse_pkg::STK_PUSH;
                new_val  = {1'b0, token_i.operand};
                out_top  = new_val;
                depth_nx = count_q + 1'b1;
              end
            end
            rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL,
            rse_pkg::OP_DIV, rse_pkg::OP_MOD: begin
              if (count_q < CW'(2)) begin
                status = rse_pkg::ST_UNDER;
              end else if (token_i.opcode == rse_pkg::OP_ADD) begin
                cmd      = rse_pkg::STK_PULL1;
                new_val  = nxt_val + top_val;
                out_top  = new_val;
                depth_nx = count_q - 1'b1;
              end else if (token_i.opcode == rse_pkg::OP_SUB) begin
                cmd      = rse_pkg::STK_PULL1;
                new_val  = nxt_val - top_val;
                out_top  = new_val;
                depth_nx = count_q - 1'b1;
              end else if (token_i.opcode == rse_pkg::OP_MUL) begin
                cmd      = rse_pkg::STK_PULL1;
                new_val  = nxt_val * top_val;
                out_top  = new_val;
                depth_nx = count_q - 1'b1;
              end else if (top_val == '0) begin
                cmd      = rse_pkg::STK_PULL2;
                status   = rse_pkg::ST_DIVZERO;
                depth_nx = count_q - CW'(2);
                out_top  = third_val;
              end else begin
                div_start = 1'b1;
                valid_d   = 1'b0;
                state_d   = rse_pkg::TS_DIV;
              end
            end
            default: status = rse_pkg::ST_UNKNOWN;
          endcase
        end
      end
      rse_pkg::TS_DIV: begin
        if (div_done) begin
          cmd      = rse_pkg::STK_PULL1;
          new_val  = div_result;
          out_top  = new_val;
          depth_nx = count_q - 1'b1;
          valid_d  = 1'b1;
          state_d  = rse_pkg::TS_IDLE;
        end
      end
      default: state_d = rse_pkg::TS_IDLE;
    endcase

    if (depth_nx == '0) begin
      out_top = '0;
    end
    res_d.top_value      = out_top;
    res_d.stack_depth    = 5'(depth_nx);
    res_d.status         = status;
    res_d.expression_end = last_d;
    // last token empties the stack after its result is formed
    count_d = (valid_d && last_d) ? '0 : depth_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rse_pkg::TS_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  // ---------------- assertions
  `RSE_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `RSE_ASSERT(a_fast_strobe, clk_i, rst_ni, (accept && !div_start) |=> result_valid_o)
  `RSE_ASSERT(a_done_in_wait, clk_i, rst_ni, div_done |-> (state_q == rse_pkg::TS_DIV))
  `RSE_ASSERT_NEVER(a_no_strobe_in_wait, clk_i, rst_ni,
                    (state_q == rse_pkg::TS_DIV) && result_valid_o)
  `RSE_ASSERT(a_depth_range, clk_i, rst_ni,
              result_valid_o |-> (result_o.stack_depth <= 5'(DEPTH)))

endmodule
